### design/hrsp_pkg.sv
// Shared types, constants and lookup functions for the HTTP response parser.
// No dependencies; every other file imports this package.
package hrsp_pkg;

    // Body length arithmetic width and the width shown on the result port
    localparam int LEN_W     = 32;
    localparam int OUT_LEN_W = 32;
    localparam int ST_W      = 11;
    localparam int POS_W     = 5;
    localparam int QDEPTH    = 4;   // power of two
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [ST_W-1:0]  ST_NONE = '1;   // -1
    localparam logic [13:0]      ST_SAT  = 14'd999;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF_HX = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;

    // Line matcher positions: status line
    localparam logic [POS_W-1:0] MP_ST_MAJOR = 5'd7;   // after "HTTP/1."
    localparam logic [POS_W-1:0] MP_ST_SEP   = 5'd8;   // in version digits
    localparam logic [POS_W-1:0] MP_ST_CODE0 = 5'd9;   // in separating spaces
    localparam logic [POS_W-1:0] MP_ST_CODE  = 5'd10;  // in status digits
    localparam logic [POS_W-1:0] MP_ST_TAIL  = 5'd11;  // rest of line
    // Line matcher positions: header line
    localparam logic [POS_W-1:0] MP_HD_NUM    = 5'd16; // after the name
    localparam logic [POS_W-1:0] MP_HD_SIGN   = 5'd17; // after a sign
    localparam logic [POS_W-1:0] MP_HD_ZERO   = 5'd18; // after leading zero
    localparam logic [POS_W-1:0] MP_HD_HEX0   = 5'd19; // after 0x
    localparam logic [POS_W-1:0] MP_HD_DIGITS = 5'd20; // in digits
    localparam logic [POS_W-1:0] MP_HD_STOP   = 5'd21; // number finished

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_STATUS  = 3'd1,
        PH_HEADERS = 3'd2,
        PH_BODY    = 3'd3,
        PH_DONE    = 3'd4,
        PH_CLOSED  = 3'd5,
        PH_BROKEN  = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_EOS   = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        RDX_DEC = 2'd0,
        RDX_OCT = 2'd1,
        RDX_HEX = 2'd2
    } t_radix;

    // One classified input item as it travels through the queue
    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
        logic       is_cr;
        logic       is_lf;
        logic       is_sp;
        logic       is_blank;
        logic       is_dec;
        logic       is_oct;
        logic       is_hex;
        logic       is_zero;
        logic       is_x;
        logic       is_sign;
        logic       is_minus;
        logic [3:0] dval;
    } t_item;

    function automatic logic [7:0] status_prefix_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return "H";
            3'd1:    return "T";
            3'd2:    return "T";
            3'd3:    return "P";
            3'd4:    return "/";
            3'd5:    return "1";
            3'd6:    return ".";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] length_prefix_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "C";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "t";
            4'd4:    return "e";
            4'd5:    return "n";
            4'd6:    return "t";
            4'd7:    return "-";
            4'd8:    return "L";
            4'd9:    return "e";
            4'd10:   return "n";
            4'd11:   return "g";
            4'd12:   return "t";
            4'd13:   return "h";
            4'd14:   return ":";
            4'd15:   return " ";
            default: return 8'h00;
        endcase
    endfunction

endpackage

### design/hrsp_if.sv
// Valid/ready channel interfaces for parser commands and parser results.
// Depends on hrsp_pkg.
interface hrsp_cmd_if import hrsp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface hrsp_res_if import hrsp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [2:0]            phase;
    logic signed [ST_W-1:0] resp_status;
    logic [OUT_LEN_W-1:0]  decl_length;
    logic                  decl_length_seen;
    logic                  body_valid;
    logic [7:0]            body_byte;

    modport source (output valid, output phase, output resp_status, output decl_length,
                    output decl_length_seen, output body_valid, output body_byte,
                    input ready);
    modport sink   (input valid, input phase, input resp_status, input decl_length,
                    input decl_length_seen, input body_valid, input body_byte,
                    output ready);
endinterface

### design/hrsp_front.sv
// Front end: accepts command transfers and classifies the data byte.
// Depends on hrsp_pkg and hrsp_if.
module hrsp_front import hrsp_pkg::*; (
    hrsp_cmd_if.sink i_cmd,
    input  logic     i_full,
    output logic     o_push,
    output t_item    o_item
);

    logic [7:0] w_b;

    assign w_b         = i_cmd.data_byte;
    assign i_cmd.ready = !i_full;
    assign o_push      = i_cmd.valid && !i_full;

    always_comb begin
        o_item          = '0;
        o_item.cmd      = t_cmd'(i_cmd.command);
        o_item.data     = w_b;
        o_item.is_cr    = (w_b == CH_CR);
        o_item.is_lf    = (w_b == CH_LF);
        o_item.is_sp    = (w_b == CH_SP);
        o_item.is_blank = w_b inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
        o_item.is_dec   = w_b inside {[CH_ZERO:CH_NINE]};
        o_item.is_oct   = w_b inside {[CH_ZERO:CH_SEVEN]};
        o_item.is_zero  = (w_b == CH_ZERO);
        o_item.is_x     = (w_b == CH_LX) || (w_b == CH_UX);
        o_item.is_sign  = (w_b == CH_PLUS) || (w_b == CH_MINUS);
        o_item.is_minus = (w_b == CH_MINUS);
        // Hex digit value; letters map to 10..15
        if (w_b inside {[CH_ZERO:CH_NINE]}) begin
            o_item.is_hex = 1'b1;
            o_item.dval   = 4'(w_b - CH_ZERO);
        end else if (w_b inside {[CH_LA:CH_LF_HX]}) begin
            o_item.is_hex = 1'b1;
            o_item.dval   = 4'(w_b - 8'h57);
        end else if (w_b inside {[CH_UA:CH_UF_HX]}) begin
            o_item.is_hex = 1'b1;
            o_item.dval   = 4'(w_b - 8'h37);
        end else begin
            o_item.is_hex = 1'b0;
            o_item.dval   = 4'd0;
        end
    end

endmodule

### design/hrsp_queue.sv
// Short FIFO of classified items between the front end and the parser core.
// Depends on hrsp_pkg.
module hrsp_queue import hrsp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty,
    output logic  o_full
);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;

    assign o_item  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_pop  ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### design/hrsp_back.sv
// Parser core: runs the line matcher, header and body state per item and
// holds the result register. Depends on hrsp_pkg and hrsp_if.
module hrsp_back import hrsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_item      i_item,
    output logic       o_pop,
    hrsp_res_if.source o_res
);

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             ok;
        logic             empty;
        logic [LEN_W-1:0] val;
        logic             neg;
        t_radix           radix;
        logic [ST_W-1:0]  st;
    } t_line;

    t_phase           r_phase, n_phase;
    t_line            r_line, n_line;
    logic             r_pcr, n_pcr;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_seen, n_seen;
    logic [LEN_W-1:0] r_bcnt, n_bcnt;
    logic             r_ovalid, n_ovalid;
    t_phase           r_ophase, n_ophase;
    logic [ST_W-1:0]  r_ost, n_ost;
    logic [OUT_LEN_W-1:0] r_olen, n_olen;
    logic             r_oseen, n_oseen;
    logic             r_obv, n_obv;
    logic [7:0]       r_obyte, n_obyte;
    logic             w_bvalid;

    function automatic t_line clear_line(input t_line s);
        t_line r;
        r       = s;
        r.pos   = '0;
        r.ok    = 1'b1;
        r.empty = 1'b1;
        r.val   = '0;
        r.neg   = 1'b0;
        r.radix = RDX_DEC;
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] sat_digit(input logic [LEN_W-1:0] v,
                                                   input t_radix rdx,
                                                   input logic [3:0] d);
        logic [LEN_W+3:0] p;
        case (rdx)
            RDX_OCT: p = {1'b0, v, 3'b000};
            RDX_HEX: p = {v, 4'b0000};
            default: p = {1'b0, v, 3'b000} + {3'b000, v, 1'b0};
        endcase
        p = p + {{LEN_W{1'b0}}, d};
        if (p[LEN_W+3:LEN_W] != 4'd0) begin
            return LEN_MAX;
        end
        return p[LEN_W-1:0];
    endfunction

    function automatic t_line feed_st(input t_line s, input t_item it);
        t_line       r;
        logic [13:0] acc;
        r   = s;
        acc = {3'b000, s.st} * 14'd10 + {10'd0, it.dval};
        if (s.ok) begin
            if (s.pos < MP_ST_MAJOR) begin
                if (it.data == status_prefix_char(s.pos[2:0])) r.pos = s.pos + 1'b1;
                else r.ok = 1'b0;
            end else begin
                case (s.pos)
                    MP_ST_MAJOR: begin
                        if (it.is_dec) r.pos = MP_ST_SEP;
                        else r.ok = 1'b0;
                    end
                    MP_ST_SEP: begin
                        if (it.is_sp) r.pos = MP_ST_CODE0;
                        else if (!it.is_dec) r.ok = 1'b0;
                    end
                    MP_ST_CODE0: begin
                        if (it.is_dec) begin
                            r.st  = ST_W'(it.dval);
                            r.pos = MP_ST_CODE;
                        end else if (!it.is_sp) begin
                            r.ok = 1'b0;
                        end
                    end
                    MP_ST_CODE: begin
                        if (it.is_dec) r.st = (acc > ST_SAT) ? ST_W'(ST_SAT) : ST_W'(acc);
                        else r.pos = MP_ST_TAIL;
                    end
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    // A CR that turned out not to end the line
    function automatic t_line feed_cr_st(input t_line s);
        t_line r;
        r = s;
        if (s.ok) begin
            if (s.pos < MP_ST_CODE) r.ok = 1'b0;
            else if (s.pos == MP_ST_CODE) r.pos = MP_ST_TAIL;
        end
        return r;
    endfunction

    function automatic t_line feed_hd(input t_line s, input t_item it);
        t_line r;
        logic  in_base;
        r       = s;
        r.empty = 1'b0;
        case (s.radix)
            RDX_OCT: in_base = it.is_oct;
            RDX_HEX: in_base = it.is_hex;
            default: in_base = it.is_dec;
        endcase
        if (s.ok) begin
            if (s.pos < MP_HD_NUM) begin
                if (it.data == length_prefix_char(s.pos[3:0])) r.pos = s.pos + 1'b1;
                else r.ok = 1'b0;
            end else begin
                case (s.pos)
                    MP_HD_NUM, MP_HD_SIGN: begin
                        if (s.pos == MP_HD_NUM && it.is_blank) begin
                            r.pos = s.pos;   // skip leading blanks
                        end else if (s.pos == MP_HD_NUM && it.is_sign) begin
                            r.neg = it.is_minus;
                            r.pos = MP_HD_SIGN;
                        end else if (it.is_zero) begin
                            r.pos = MP_HD_ZERO;
                        end else if (it.is_dec) begin
                            r.radix = RDX_DEC;
                            r.val   = LEN_W'(it.dval);
                            r.pos   = MP_HD_DIGITS;
                        end else begin
                            r.pos = MP_HD_STOP;
                        end
                    end
                    MP_HD_ZERO: begin
                        if (it.is_x) begin
                            r.pos = MP_HD_HEX0;
                        end else if (it.is_oct) begin
                            r.radix = RDX_OCT;
                            r.val   = LEN_W'(it.dval);
                            r.pos   = MP_HD_DIGITS;
                        end else begin
                            r.pos = MP_HD_STOP;
                        end
                    end
                    MP_HD_HEX0: begin
                        if (it.is_hex) begin
                            r.radix = RDX_HEX;
                            r.val   = LEN_W'(it.dval);
                            r.pos   = MP_HD_DIGITS;
                        end else begin
                            r.pos = MP_HD_STOP;
                        end
                    end
                    MP_HD_DIGITS: begin
                        if (in_base) r.val = sat_digit(s.val, s.radix, it.dval);
                        else r.pos = MP_HD_STOP;
                    end
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    function automatic t_line feed_cr_hd(input t_line s);
        t_line r;
        r       = s;
        r.empty = 1'b0;
        if (s.ok) begin
            if (s.pos < MP_HD_NUM) r.ok = 1'b0;
            else if (s.pos > MP_HD_NUM && s.pos < MP_HD_STOP) r.pos = MP_HD_STOP;
        end
        return r;
    endfunction

    assign o_pop = !i_empty && (!r_ovalid || o_res.ready);

    always_comb begin
        t_line            s;
        logic             is_st;
        logic [LEN_W-1:0] cnt;
        s        = r_line;
        is_st    = (r_phase == PH_STATUS);
        cnt      = (r_bcnt != LEN_MAX) ? r_bcnt + 1'b1 : r_bcnt;
        n_phase  = r_phase;
        n_line   = r_line;
        n_pcr    = r_pcr;
        n_len    = r_len;
        n_seen   = r_seen;
        n_bcnt   = r_bcnt;
        w_bvalid = 1'b0;
        if (o_pop) begin
            case (i_item.cmd)
                CMD_START: begin
                    n_phase   = PH_STATUS;
                    n_pcr     = 1'b0;
                    n_len     = '0;
                    n_seen    = 1'b0;
                    n_bcnt    = '0;
                    n_line    = clear_line(r_line);
                    n_line.st = ST_NONE;
                end
                CMD_DATA: begin
                    case (r_phase)
                        PH_STATUS, PH_HEADERS: begin
                            if (r_pcr && i_item.is_lf) begin
                                // end of line
                                n_pcr = 1'b0;
                                if (is_st) begin
                                    if (s.ok && s.pos >= MP_ST_CODE) begin
                                        n_phase = PH_HEADERS;
                                    end else begin
                                        n_phase = PH_BROKEN;
                                        s.st    = ST_NONE;
                                    end
                                end else if (s.empty) begin
                                    n_bcnt  = '0;
                                    n_phase = (r_seen && r_len == '0) ? PH_DONE : PH_BODY;
                                end else if (s.ok && s.pos >= MP_HD_NUM) begin
                                    n_len  = (s.neg && s.val != '0) ? LEN_MAX : s.val;
                                    n_seen = 1'b1;
                                end
                                n_line = clear_line(s);
                            end else begin
                                if (r_pcr) s = is_st ? feed_cr_st(s) : feed_cr_hd(s);
                                if (!i_item.is_cr) s = is_st ? feed_st(s, i_item)
                                                             : feed_hd(s, i_item);
                                n_pcr  = i_item.is_cr;
                                n_line = s;
                            end
                        end
                        PH_BODY: begin
                            w_bvalid = 1'b1;
                            n_bcnt   = cnt;
                            if (r_seen && cnt >= r_len) n_phase = PH_DONE;
                        end
                        default: ;
                    endcase
                end
                CMD_EOS: begin
                    case (r_phase)
                        PH_STATUS: begin
                            n_phase   = PH_BROKEN;
                            n_line.st = ST_NONE;
                        end
                        PH_HEADERS: n_phase = PH_BROKEN;
                        PH_BODY:    n_phase = r_seen ? PH_BROKEN : PH_CLOSED;
                        PH_DONE:    n_phase = PH_CLOSED;
                        default: ;
                    endcase
                    n_pcr = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Result register: load on pop, drop once the transfer completes
    always_comb begin
        n_ovalid = r_ovalid;
        n_ophase = r_ophase;
        n_ost    = r_ost;
        n_olen   = r_olen;
        n_oseen  = r_oseen;
        n_obv    = r_obv;
        n_obyte  = r_obyte;
        if (o_pop) begin
            n_ovalid = 1'b1;
            n_ophase = n_phase;
            n_ost    = (n_phase == PH_STATUS) ? ST_NONE : n_line.st;
            n_olen   = n_len[OUT_LEN_W-1:0];
            n_oseen  = n_seen;
            n_obv    = w_bvalid;
            n_obyte  = w_bvalid ? i_item.data : 8'h00;
        end else if (o_res.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_line   <= '{pos: '0, ok: 1'b1, empty: 1'b1, val: '0, neg: 1'b0,
                          radix: RDX_DEC, st: ST_NONE};
            r_pcr    <= 1'b0;
            r_len    <= '0;
            r_seen   <= 1'b0;
            r_bcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_line   <= n_line;
            r_pcr    <= n_pcr;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_bcnt   <= n_bcnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ophase <= n_ophase;
        r_ost    <= n_ost;
        r_olen   <= n_olen;
        r_oseen  <= n_oseen;
        r_obv    <= n_obv;
        r_obyte  <= n_obyte;
    end

    assign o_res.valid            = r_ovalid;
    assign o_res.phase            = r_ophase;
    assign o_res.resp_status      = $signed(r_ost);
    assign o_res.decl_length      = r_olen;
    assign o_res.decl_length_seen = r_oseen;
    assign o_res.body_valid       = r_obv;
    assign o_res.body_byte        = r_obyte;

endmodule

### design/http_response_stream_parser_unit.sv
// HTTP/1.x response header parser, one byte per transfer.
//
// i_cmd carries one command per transfer: start of a new response, one data
// byte, or end of stream. o_res returns exactly one result per command: the
// parse phase, the status code (-1 until the status line is accepted), the
// committed Content-Length and its flag, and the body byte when the data
// byte belongs to the body.
// The front end classifies each byte and writes it into a four-entry queue;
// the parser core pops one item per cycle while o_res does not stall,
// updates its line matcher, header and body state in that cycle, then
// loads the result register. Each command passes through the queue and
// then the result register on its way to o_res. Throughput: one command
// per clock while o_res is ready, set by the single state update in the core.
// When o_res stalls, the result register holds, the queue fills and i_cmd
// ready drops once four items wait behind the held result.
// Reset clears the queue, empties the result register and puts the parser in
// the idle phase with no status and no length.
// Depends on hrsp_pkg, hrsp_if, hrsp_front, hrsp_queue and hrsp_back.
module http_response_stream_parser_unit import hrsp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrsp_cmd_if.sink   i_cmd,
    hrsp_res_if.source o_res
);

    t_item w_item;
    t_item w_qitem;
    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;

    hrsp_front u_front (
        .i_cmd  (i_cmd),
        .i_full (w_full),
        .o_push (w_push),
        .o_item (w_item)
    );

    hrsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_item  (w_qitem),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    hrsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_qitem),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for http_response_stream_parser_unit: drives byte streams of
// HTTP responses and checks every parser report against a behavioral predictor.
// Depends on hrsp_pkg, hrsp_if and the parser RTL.
module tb import hrsp_pkg::*;;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int STREAM_ITEMS    = 1300;
    localparam int HOLD_CYCLES     = 120;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] b;
    } t_stream_item;

    typedef struct packed {
        t_phase          phase;
        logic [ST_W-1:0] status;
        logic [31:0]     clen;
        logic            has_clen;
        logic            body_valid;
        logic [7:0]      body_byte;
    } t_parse_report;

    logic clk;
    logic rst_n;

    hrsp_cmd_if cmd_ch ();
    hrsp_res_if res_ch ();

    http_response_stream_parser_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    t_stream_item  byte_stream[$];
    t_parse_report reports_due[$];

    int errors      = 0;
    int cmds_taken  = 0;
    int idle_cycles = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int rcv_mode    = 0;
    int rcv_left    = 0;
    int rcv_tick    = 0;
    int hold_left   = 0;
    int holds_done  = 0;
    logic cmd_fire  = 1'b0;

    string status_tag = "HTTP/1.";
    string length_tag = "Content-Length: ";

    // Parser state as the predictor sees it
    t_phase      m_phase;
    logic [4:0]  m_pos;
    logic        m_prefix_ok;
    logic        m_blank_line;
    logic        m_cr_held;
    int          m_status;
    logic [31:0] m_clen;
    logic        m_clen_seen;
    logic [31:0] m_body_seen;
    logic [31:0] m_num;
    logic        m_num_neg;
    t_radix      m_radix;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [4:0] char_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF_HX) return 5'(c - CH_LA + 8'd10);
        if (c >= CH_UA && c <= CH_UF_HX) return 5'(c - CH_UA + 8'd10);
        return 5'd16;
    endfunction

    function automatic logic is_space_char(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF
            || c == CH_CR;
    endfunction

    function automatic logic [31:0] sat_push(input logic [31:0] v, input int unsigned base,
                                             input logic [4:0] d);
        longint unsigned cap;
        cap = (64'hFFFF_FFFF - d) / base;
        if ({32'b0, v} > cap) return '1;
        return 32'({32'b0, v} * base + d);
    endfunction

    function automatic void clear_line();
        m_pos        = '0;
        m_prefix_ok  = 1'b1;
        m_blank_line = 1'b1;
        m_num        = '0;
        m_num_neg    = 1'b0;
        m_radix      = RDX_DEC;
    endfunction

    function automatic void reset_parser();
        m_phase     = PH_IDLE;
        m_cr_held   = 1'b0;
        m_status    = -1;
        m_clen      = '0;
        m_clen_seen = 1'b0;
        m_body_seen = '0;
        clear_line();
    endfunction

    function automatic void status_char(input logic [7:0] c);
        logic dig;
        dig = c >= CH_ZERO && c <= CH_NINE;
        if (!m_prefix_ok) return;
        if (m_pos < MP_ST_MAJOR) begin
            if (c == status_tag[m_pos]) m_pos = m_pos + 1'b1;
            else m_prefix_ok = 1'b0;
        end else if (m_pos == MP_ST_MAJOR) begin
            if (dig) m_pos = MP_ST_SEP;
            else m_prefix_ok = 1'b0;
        end else if (m_pos == MP_ST_SEP) begin
            if (c == CH_SP) m_pos = MP_ST_CODE0;
            else if (!dig) m_prefix_ok = 1'b0;
        end else if (m_pos == MP_ST_CODE0) begin
            if (dig) begin
                m_status = int'(c - CH_ZERO);
                m_pos    = MP_ST_CODE;
            end else if (c != CH_SP) begin
                m_prefix_ok = 1'b0;
            end
        end else if (m_pos == MP_ST_CODE) begin
            if (dig) begin
                m_status = m_status * 10 + int'(c - CH_ZERO);
                if (m_status > 999) m_status = 999;
            end else begin
                m_pos = MP_ST_TAIL;
            end
        end
    endfunction

    function automatic void header_char(input logic [7:0] c);
        logic [4:0]  d;
        int unsigned base;
        d = char_digit(c);
        m_blank_line = 1'b0;
        if (!m_prefix_ok) return;
        if (m_pos < MP_HD_NUM) begin
            if (c == length_tag[m_pos]) m_pos = m_pos + 1'b1;
            else m_prefix_ok = 1'b0;
        end else if (m_pos == MP_HD_NUM || m_pos == MP_HD_SIGN) begin
            // skip leading white space, then at most one sign
            if (m_pos == MP_HD_NUM && is_space_char(c)) return;
            if (m_pos == MP_HD_NUM && (c == CH_PLUS || c == CH_MINUS)) begin
                m_num_neg = c == CH_MINUS;
                m_pos     = MP_HD_SIGN;
            end else if (c == CH_ZERO) begin
                m_pos = MP_HD_ZERO;
            end else if (d >= 5'd1 && d <= 5'd9 && c <= CH_NINE) begin
                m_radix = RDX_DEC;
                m_num   = 32'(d);
                m_pos   = MP_HD_DIGITS;
            end else begin
                m_pos = MP_HD_STOP;
            end
        end else if (m_pos == MP_HD_ZERO) begin
            if (c == CH_LX || c == CH_UX) begin
                m_pos = MP_HD_HEX0;
            end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                m_radix = RDX_OCT;
                m_num   = 32'(d);
                m_pos   = MP_HD_DIGITS;
            end else begin
                m_pos = MP_HD_STOP;
            end
        end else if (m_pos == MP_HD_HEX0) begin
            if (d < 5'd16) begin
                m_radix = RDX_HEX;
                m_num   = 32'(d);
                m_pos   = MP_HD_DIGITS;
            end else begin
                m_pos = MP_HD_STOP;
            end
        end else if (m_pos == MP_HD_DIGITS) begin
            base = (m_radix == RDX_OCT) ? 8 : ((m_radix == RDX_HEX) ? 16 : 10);
            if (d < base) m_num = sat_push(m_num, base, d);
            else m_pos = MP_HD_STOP;
        end
    endfunction

    function automatic void line_char(input logic [7:0] c);
        if (m_phase == PH_STATUS) status_char(c);
        else header_char(c);
    endfunction

    function automatic void line_done();
        if (m_phase == PH_STATUS) begin
            if (m_prefix_ok && m_pos >= MP_ST_CODE) begin
                m_phase = PH_HEADERS;
            end else begin
                m_phase  = PH_BROKEN;
                m_status = -1;
            end
        end else if (m_blank_line) begin
            m_body_seen = '0;
            m_phase     = (m_clen_seen && m_clen == 0) ? PH_DONE : PH_BODY;
        end else if (m_prefix_ok && m_pos >= MP_HD_NUM) begin
            m_clen      = (m_num_neg && m_num != 0) ? '1 : m_num;
            m_clen_seen = 1'b1;
        end
        clear_line();
    endfunction

    function automatic t_parse_report predict_report(input t_cmd cmd, input logic [7:0] b);
        t_parse_report r;
        logic          in_body;
        in_body = 1'b0;
        case (cmd)
            CMD_START: begin
                reset_parser();
                m_phase = PH_STATUS;
            end
            CMD_DATA: begin
                if (m_phase == PH_STATUS || m_phase == PH_HEADERS) begin
                    if (m_cr_held) begin
                        if (b == CH_LF) begin
                            m_cr_held = 1'b0;
                            line_done();
                        end else begin
                            // a CR without LF is an ordinary character
                            line_char(CH_CR);
                            if (b != CH_CR) begin
                                m_cr_held = 1'b0;
                                line_char(b);
                            end
                        end
                    end else if (b == CH_CR) begin
                        m_cr_held = 1'b1;
                    end else begin
                        line_char(b);
                    end
                end else if (m_phase == PH_BODY) begin
                    in_body = 1'b1;
                    if (m_body_seen != '1) m_body_seen = m_body_seen + 1;
                    if (m_clen_seen && m_body_seen >= m_clen) m_phase = PH_DONE;
                end
            end
            CMD_EOS: begin
                if (m_phase == PH_STATUS) begin
                    m_status = -1;
                    m_phase  = PH_BROKEN;
                end else if (m_phase == PH_HEADERS) begin
                    m_phase = PH_BROKEN;
                end else if (m_phase == PH_BODY) begin
                    m_phase = m_clen_seen ? PH_BROKEN : PH_CLOSED;
                end else if (m_phase == PH_DONE) begin
                    m_phase = PH_CLOSED;
                end
                m_cr_held = 1'b0;
            end
            default: ;
        endcase
        r.phase      = m_phase;
        r.status     = (m_phase == PH_STATUS) ? ST_NONE : ST_W'(m_status);
        r.clen       = m_clen;
        r.has_clen   = m_clen_seen;
        r.body_valid = in_body;
        r.body_byte  = in_body ? b : 8'h00;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic add_cmd(input t_cmd cmd, input logic [7:0] b);
        t_stream_item it;
        it.cmd = cmd;
        it.b   = b;
        byte_stream.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_cmd(CMD_DATA, s[i]);
    endtask

    task automatic add_eol();
        // now and then a doubled CR ahead of the line end
        if ($urandom_range(0, 11) == 0) add_cmd(CMD_DATA, CH_CR);
        add_cmd(CMD_DATA, CH_CR);
        add_cmd(CMD_DATA, CH_LF);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 4))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_VT;
            3:       return CH_FF;
            default: return CH_LF;
        endcase
    endfunction

    task automatic add_status_line();
        int    kind;
        string s;
        kind = $urandom_range(0, 13);
        if (kind == 5) begin
            add_eol();
            return;
        end
        s = "HTTP/1.";
        if (kind == 1) s[$urandom_range(0, 6)] = 8'($urandom_range(0, 255));
        if (kind != 2) s = {s, $sformatf("%0d", $urandom_range(0, 12))};
        if (kind == 3) s = {s, "\t"};
        else repeat ($urandom_range(1, 3)) s = {s, " "};
        if (kind == 6) s = {s, $sformatf("%0d", $urandom_range(1000, 2000000))};
        else if (kind == 7) s = {s, $sformatf("%04d", $urandom_range(0, 999))};
        else if (kind != 4) s = {s, $sformatf("%0d", $urandom_range(100, 599))};
        add_text(s);
        case ($urandom_range(0, 5))
            0: add_text(" OK");
            1: begin
                add_cmd(CMD_DATA, CH_CR);
                add_text("x");
            end
            2: repeat ($urandom_range(1, 4)) add_cmd(CMD_DATA, 8'($urandom_range(33, 126)));
            default: ;
        endcase
        add_eol();
    endtask

    task automatic add_length_header(output int body_len);
        int    form;
        int    n;
        string v;
        form     = $urandom_range(0, 13);
        n        = $urandom_range(0, 12);
        body_len = n;
        if (form == 0) add_text("Content-length: ");
        else if (form == 1) add_text("Content-Length:");
        else add_text("Content-Length: ");
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_cmd(CMD_DATA, pick_space());
        if (form == 13) add_cmd(CMD_DATA, CH_CR);
        if ($urandom_range(0, 9) == 0) begin
            add_cmd(CMD_DATA, CH_MINUS);
            if (n != 0) body_len = 20;
        end else if ($urandom_range(0, 7) == 0) begin
            add_cmd(CMD_DATA, CH_PLUS);
        end
        case (form)
            6, 7: begin
                v = $sformatf("0x%0h", n);
                if (form == 7) v = v.toupper();
            end
            8: v = $sformatf("0%0o", n);
            9: begin
                if ($urandom_range(0, 1) != 0) v = "4294967295";
                else v = "99999999999";
                body_len = 20;
            end
            10: begin
                v        = "0xFFFFFFFFF";
                body_len = 20;
            end
            11: begin
                case ($urandom_range(0, 3))
                    0:       v = "";
                    1:       v = "0x";
                    2:       v = "09";
                    default: v = "0xg";
                endcase
                body_len = 0;
            end
            12: v = $sformatf("%0d;x", n);
            default: v = $sformatf("%0d", n);
        endcase
        add_text(v);
        add_eol();
    endtask

    task automatic add_other_header();
        case ($urandom_range(0, 3))
            0: add_text("Host: h");
            1: add_text("Content-Len: 4");
            2: add_text("Content-Length 7");
            default: repeat ($urandom_range(1, 6)) add_cmd(CMD_DATA, 8'($urandom_range(33, 126)));
        endcase
        add_eol();
    endtask

    task automatic add_response();
        int shape;
        int n;
        int body_len;
        int sent;
        bit have_len;
        add_cmd(CMD_START, 8'($urandom_range(0, 255)));
        add_status_line();
        shape    = $urandom_range(0, 19);
        have_len = 1'b0;
        body_len = 0;
        if (shape == 0) begin
            add_cmd(CMD_EOS, 8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 2) != 0) begin
                add_length_header(n);
                body_len = n;
                have_len = 1'b1;
            end else begin
                add_other_header();
            end
        end
        // abort in the middle of the headers
        if (shape == 1) begin
            add_cmd(CMD_START, 8'($urandom_range(0, 255)));
            return;
        end
        add_eol();
        if (!have_len) body_len = $urandom_range(0, 10);
        if (shape < 4) sent = $urandom_range(0, body_len);
        else if (shape == 4) sent = body_len + $urandom_range(1, 3);
        else sent = body_len;
        repeat (sent) add_cmd(CMD_DATA, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) != 0) add_cmd(CMD_EOS, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0) add_cmd(CMD_EOS, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_directed();
        add_cmd(CMD_NOP, 8'hFF);
        add_cmd(CMD_DATA, 8'h00);
        add_cmd(CMD_EOS, 8'h5A);
        add_cmd(CMD_START, 8'hA5);
        add_text("HTTP/1.1 204");
        add_cmd(CMD_DATA, CH_CR);
        add_cmd(CMD_DATA, CH_LF);
        add_cmd(CMD_DATA, CH_CR);
        add_cmd(CMD_DATA, CH_LF);
        add_cmd(CMD_DATA, 8'hFF);
        add_cmd(CMD_EOS, 8'h00);
        add_cmd(CMD_DATA, 8'h80);
        add_cmd(CMD_NOP, 8'h00);
        add_cmd(CMD_START, 8'h00);
        add_cmd(CMD_EOS, 8'hFF);
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge clk) begin : cmd_driver
        t_stream_item it;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_fire) begin
            if (gap_left > 0 || byte_stream.size() == 0) begin
                cmd_ch.valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                it = byte_stream.pop_front();
                cmd_ch.valid     <= 1'b1;
                cmd_ch.command   <= it.cmd;
                cmd_ch.data_byte <= it.b;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // Long hold-off on the result side so the input queue fills and stalls
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (holds_done < 2 && cmds_taken >= 300 + 600 * holds_done) begin
                hold_left  <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
            end
        end
    end

    always @(negedge clk) begin : res_receiver
        logic take;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (rcv_left == 0) begin
                rcv_mode = $urandom_range(0, 3);
                rcv_left = $urandom_range(30, 200);
            end else begin
                rcv_left--;
            end
            rcv_tick++;
            case (rcv_mode)
                0:       take = 1'b1;
                1:       take = $urandom_range(0, 1) != 0;
                2:       take = $urandom_range(0, 3) != 0;
                default: take = (rcv_tick % 8) < 5;
            endcase
            res_ch.ready <= take && hold_left == 0;
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic check_report();
        t_parse_report want;
        if (reports_due.size() == 0) begin
            $error("unexpected result: phase %0d", res_ch.phase);
            errors++;
            return;
        end
        want = reports_due.pop_front();
        if (res_ch.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, res_ch.phase);
            errors++;
        end
        if (res_ch.resp_status !== want.status) begin
            $error("resp_status: expected %0d, got %0d", $signed(want.status),
                   res_ch.resp_status);
            errors++;
        end
        if (res_ch.decl_length !== want.clen) begin
            $error("decl_length: expected %0d, got %0d", want.clen, res_ch.decl_length);
            errors++;
        end
        if (res_ch.decl_length_seen !== want.has_clen) begin
            $error("decl_length_seen: expected %0d, got %0d", want.has_clen,
                   res_ch.decl_length_seen);
            errors++;
        end
        if (res_ch.body_valid !== want.body_valid) begin
            $error("body_valid: expected %0d, got %0d", want.body_valid, res_ch.body_valid);
            errors++;
        end
        if (res_ch.body_byte !== want.body_byte) begin
            $error("body_byte: expected %0h, got %0h", want.body_byte, res_ch.body_byte);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        cmd_fire <= cmd_ch.valid && cmd_ch.ready;
        if (rst_n) begin
            // check the older transfer first: a result never belongs to this edge's input
            if (res_ch.valid && res_ch.ready) check_report();
            if (cmd_ch.valid && cmd_ch.ready) begin
                reports_due.push_back(predict_report(t_cmd'(cmd_ch.command), cmd_ch.data_byte));
                cmds_taken++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        rst_n            = 1'b0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.command   = '0;
        cmd_ch.data_byte = '0;
        res_ch.ready     = 1'b0;
        reset_parser();
        add_directed();
        while (byte_stream.size() < STREAM_ITEMS) begin
            add_response();
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4))
                    add_cmd(t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (byte_stream.size() != 0 || cmd_ch.valid || reports_due.size() != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
design/hrsp_pkg.sv
design/hrsp_if.sv
design/hrsp_front.sv
design/hrsp_queue.sv
design/hrsp_back.sv
design/http_response_stream_parser_unit.sv
sim/tb.sv
